// File: hdl/hpe_pkg.sv
`default_nettype none
package hpe_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int FIELD_CW = 16;
  localparam int QUEUE_W = 37;
  localparam int CODE_W = 30;
  localparam int LEN_W = 5;
  localparam int BITS_W = 6;
  localparam int CTX_W = QUEUE_W + BITS_W + 2;
  localparam logic [7:0] BYTE_ONES = 8'hFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_EMIT,
    ST_PAD,
    ST_ABORT
  } state_t;

  // Context word kept in the string memory.
  typedef struct packed {
    logic [QUEUE_W-1:0] queue;
    logic [BITS_W-1:0]  count;
    logic               in_string;
    logic               discarding;
  } ctx_t;

  function automatic logic [34:0] code_entry(input logic [7:0] s);
    logic [29:0] c;
    logic [4:0]  l;
    c = '0;
    l = '0;
    case (s)
      8'd0: begin c = 30'h1ff8; l = 5'd13; end
      8'd1: begin c = 30'h7fffd8; l = 5'd23; end
      8'd2: begin c = 30'hfffffe2; l = 5'd28; end
      8'd3: begin c = 30'hfffffe3; l = 5'd28; end
      8'd4: begin c = 30'hfffffe4; l = 5'd28; end
      8'd5: begin c = 30'hfffffe5; l = 5'd28; end
      8'd6: begin c = 30'hfffffe6; l = 5'd28; end
      8'd7: begin c = 30'hfffffe7; l = 5'd28; end
      8'd8: begin c = 30'hfffffe8; l = 5'd28; end
      8'd9: begin c = 30'hffffea; l = 5'd24; end
      8'd10: begin c = 30'h3ffffffc; l = 5'd30; end
      8'd11: begin c = 30'hfffffe9; l = 5'd28; end
      8'd12: begin c = 30'hfffffea; l = 5'd28; end
      8'd13: begin c = 30'h3ffffffd; l = 5'd30; end
      8'd14: begin c = 30'hfffffeb; l = 5'd28; end
      8'd15: begin c = 30'hfffffec; l = 5'd28; end
      8'd16: begin c = 30'hfffffed; l = 5'd28; end
      8'd17: begin c = 30'hfffffee; l = 5'd28; end
      8'd18: begin c = 30'hfffffef; l = 5'd28; end
      8'd19: begin c = 30'hffffff0; l = 5'd28; end
      8'd20: begin c = 30'hffffff1; l = 5'd28; end
      8'd21: begin c = 30'hffffff2; l = 5'd28; end
      8'd22: begin c = 30'h3ffffffe; l = 5'd30; end
      8'd23: begin c = 30'hffffff3; l = 5'd28; end
      8'd24: begin c = 30'hffffff4; l = 5'd28; end
      8'd25: begin c = 30'hffffff5; l = 5'd28; end
      8'd26: begin c = 30'hffffff6; l = 5'd28; end
      8'd27: begin c = 30'hffffff7; l = 5'd28; end
      8'd28: begin c = 30'hffffff8; l = 5'd28; end
      8'd29: begin c = 30'hffffff9; l = 5'd28; end
      8'd30: begin c = 30'hffffffa; l = 5'd28; end
      8'd31: begin c = 30'hffffffb; l = 5'd28; end
      8'd32: begin c = 30'h14; l = 5'd6; end
      8'd33: begin c = 30'h3f8; l = 5'd10; end
      8'd34: begin c = 30'h3f9; l = 5'd10; end
      8'd35: begin c = 30'hffa; l = 5'd12; end
      8'd36: begin c = 30'h1ff9; l = 5'd13; end
      8'd37: begin c = 30'h15; l = 5'd6; end
      8'd38: begin c = 30'hf8; l = 5'd8; end
      8'd39: begin c = 30'h7fa; l = 5'd11; end
      8'd40: begin c = 30'h3fa; l = 5'd10; end
      8'd41: begin c = 30'h3fb; l = 5'd10; end
      8'd42: begin c = 30'hf9; l = 5'd8; end
      8'd43: begin c = 30'h7fb; l = 5'd11; end
      8'd44: begin c = 30'hfa; l = 5'd8; end
      8'd45: begin c = 30'h16; l = 5'd6; end
      8'd46: begin c = 30'h17; l = 5'd6; end
      8'd47: begin c = 30'h18; l = 5'd6; end
      8'd48: begin c = 30'h0; l = 5'd5; end
      8'd49: begin c = 30'h1; l = 5'd5; end
      8'd50: begin c = 30'h2; l = 5'd5; end
      8'd51: begin c = 30'h19; l = 5'd6; end
      8'd52: begin c = 30'h1a; l = 5'd6; end
      8'd53: begin c = 30'h1b; l = 5'd6; end
      8'd54: begin c = 30'h1c; l = 5'd6; end
      8'd55: begin c = 30'h1d; l = 5'd6; end
      8'd56: begin c = 30'h1e; l = 5'd6; end
      8'd57: begin c = 30'h1f; l = 5'd6; end
      8'd58: begin c = 30'h5c; l = 5'd7; end
      8'd59: begin c = 30'hfb; l = 5'd8; end
      8'd60: begin c = 30'h7ffc; l = 5'd15; end
      8'd61: begin c = 30'h20; l = 5'd6; end
      8'd62: begin c = 30'hffb; l = 5'd12; end
      8'd63: begin c = 30'h3fc; l = 5'd10; end
      8'd64: begin c = 30'h1ffa; l = 5'd13; end
      8'd65: begin c = 30'h21; l = 5'd6; end
      8'd66: begin c = 30'h5d; l = 5'd7; end
      8'd67: begin c = 30'h5e; l = 5'd7; end
      8'd68: begin c = 30'h5f; l = 5'd7; end
      8'd69: begin c = 30'h60; l = 5'd7; end
      8'd70: begin c = 30'h61; l = 5'd7; end
      8'd71: begin c = 30'h62; l = 5'd7; end
      8'd72: begin c = 30'h63; l = 5'd7; end
      8'd73: begin c = 30'h64; l = 5'd7; end
      8'd74: begin c = 30'h65; l = 5'd7; end
      8'd75: begin c = 30'h66; l = 5'd7; end
      8'd76: begin c = 30'h67; l = 5'd7; end
      8'd77: begin c = 30'h68; l = 5'd7; end
      8'd78: begin c = 30'h69; l = 5'd7; end
      8'd79: begin c = 30'h6a; l = 5'd7; end
      8'd80: begin c = 30'h6b; l = 5'd7; end
      8'd81: begin c = 30'h6c; l = 5'd7; end
      8'd82: begin c = 30'h6d; l = 5'd7; end
      8'd83: begin c = 30'h6e; l = 5'd7; end
      8'd84: begin c = 30'h6f; l = 5'd7; end
      8'd85: begin c = 30'h70; l = 5'd7; end
      8'd86: begin c = 30'h71; l = 5'd7; end
      8'd87: begin c = 30'h72; l = 5'd7; end
      8'd88: begin c = 30'hfc; l = 5'd8; end
      8'd89: begin c = 30'h73; l = 5'd7; end
      8'd90: begin c = 30'hfd; l = 5'd8; end
      8'd91: begin c = 30'h1ffb; l = 5'd13; end
      8'd92: begin c = 30'h7fff0; l = 5'd19; end
      8'd93: begin c = 30'h1ffc; l = 5'd13; end
      8'd94: begin c = 30'h3ffc; l = 5'd14; end
      8'd95: begin c = 30'h22; l = 5'd6; end
      8'd96: begin c = 30'h7ffd; l = 5'd15; end
      8'd97: begin c = 30'h3; l = 5'd5; end
      8'd98: begin c = 30'h23; l = 5'd6; end
      8'd99: begin c = 30'h4; l = 5'd5; end
      8'd100: begin c = 30'h24; l = 5'd6; end
      8'd101: begin c = 30'h5; l = 5'd5; end
      8'd102: begin c = 30'h25; l = 5'd6; end
      8'd103: begin c = 30'h26; l = 5'd6; end
      8'd104: begin c = 30'h27; l = 5'd6; end
      8'd105: begin c = 30'h6; l = 5'd5; end
      8'd106: begin c = 30'h74; l = 5'd7; end
      8'd107: begin c = 30'h75; l = 5'd7; end
      8'd108: begin c = 30'h28; l = 5'd6; end
      8'd109: begin c = 30'h29; l = 5'd6; end
      8'd110: begin c = 30'h2a; l = 5'd6; end
      8'd111: begin c = 30'h7; l = 5'd5; end
      8'd112: begin c = 30'h2b; l = 5'd6; end
      8'd113: begin c = 30'h76; l = 5'd7; end
      8'd114: begin c = 30'h2c; l = 5'd6; end
      8'd115: begin c = 30'h8; l = 5'd5; end
      8'd116: begin c = 30'h9; l = 5'd5; end
      8'd117: begin c = 30'h2d; l = 5'd6; end
      8'd118: begin c = 30'h77; l = 5'd7; end
      8'd119: begin c = 30'h78; l = 5'd7; end
      8'd120: begin c = 30'h79; l = 5'd7; end
      8'd121: begin c = 30'h7a; l = 5'd7; end
      8'd122: begin c = 30'h7b; l = 5'd7; end
      8'd123: begin c = 30'h7ffe; l = 5'd15; end
      8'd124: begin c = 30'h7fc; l = 5'd11; end
      8'd125: begin c = 30'h3ffd; l = 5'd14; end
      8'd126: begin c = 30'h1ffd; l = 5'd13; end
      8'd127: begin c = 30'hffffffc; l = 5'd28; end
      8'd128: begin c = 30'hfffe6; l = 5'd20; end
      8'd129: begin c = 30'h3fffd2; l = 5'd22; end
      8'd130: begin c = 30'hfffe7; l = 5'd20; end
      8'd131: begin c = 30'hfffe8; l = 5'd20; end
      8'd132: begin c = 30'h3fffd3; l = 5'd22; end
      8'd133: begin c = 30'h3fffd4; l = 5'd22; end
      8'd134: begin c = 30'h3fffd5; l = 5'd22; end
      8'd135: begin c = 30'h7fffd9; l = 5'd23; end
      8'd136: begin c = 30'h3fffd6; l = 5'd22; end
      8'd137: begin c = 30'h7fffda; l = 5'd23; end
      8'd138: begin c = 30'h7fffdb; l = 5'd23; end
      8'd139: begin c = 30'h7fffdc; l = 5'd23; end
      8'd140: begin c = 30'h7fffdd; l = 5'd23; end
      8'd141: begin c = 30'h7fffde; l = 5'd23; end
      8'd142: begin c = 30'hffffeb; l = 5'd24; end
      8'd143: begin c = 30'h7fffdf; l = 5'd23; end
      8'd144: begin c = 30'hffffec; l = 5'd24; end
      8'd145: begin c = 30'hffffed; l = 5'd24; end
      8'd146: begin c = 30'h3fffd7; l = 5'd22; end
      8'd147: begin c = 30'h7fffe0; l = 5'd23; end
      8'd148: begin c = 30'hffffee; l = 5'd24; end
      8'd149: begin c = 30'h7fffe1; l = 5'd23; end
      8'd150: begin c = 30'h7fffe2; l = 5'd23; end
      8'd151: begin c = 30'h7fffe3; l = 5'd23; end
      8'd152: begin c = 30'h7fffe4; l = 5'd23; end
      8'd153: begin c = 30'h1fffdc; l = 5'd21; end
      8'd154: begin c = 30'h3fffd8; l = 5'd22; end
      8'd155: begin c = 30'h7fffe5; l = 5'd23; end
      8'd156: begin c = 30'h3fffd9; l = 5'd22; end
      8'd157: begin c = 30'h7fffe6; l = 5'd23; end
      8'd158: begin c = 30'h7fffe7; l = 5'd23; end
      8'd159: begin c = 30'hffffef; l = 5'd24; end
      8'd160: begin c = 30'h3fffda; l = 5'd22; end
      8'd161: begin c = 30'h1fffdd; l = 5'd21; end
      8'd162: begin c = 30'hfffe9; l = 5'd20; end
      8'd163: begin c = 30'h3fffdb; l = 5'd22; end
      8'd164: begin c = 30'h3fffdc; l = 5'd22; end
      8'd165: begin c = 30'h7fffe8; l = 5'd23; end
      8'd166: begin c = 30'h7fffe9; l = 5'd23; end
      8'd167: begin c = 30'h1fffde; l = 5'd21; end
      8'd168: begin c = 30'h7fffea; l = 5'd23; end
      8'd169: begin c = 30'h3fffdd; l = 5'd22; end
      8'd170: begin c = 30'h3fffde; l = 5'd22; end
      8'd171: begin c = 30'hfffff0; l = 5'd24; end
      8'd172: begin c = 30'h1fffdf; l = 5'd21; end
      8'd173: begin c = 30'h3fffdf; l = 5'd22; end
      8'd174: begin c = 30'h7fffeb; l = 5'd23; end
      8'd175: begin c = 30'h7fffec; l = 5'd23; end
      8'd176: begin c = 30'h1fffe0; l = 5'd21; end
      8'd177: begin c = 30'h1fffe1; l = 5'd21; end
      8'd178: begin c = 30'h3fffe0; l = 5'd22; end
      8'd179: begin c = 30'h1fffe2; l = 5'd21; end
      8'd180: begin c = 30'h7fffed; l = 5'd23; end
      8'd181: begin c = 30'h3fffe1; l = 5'd22; end
      8'd182: begin c = 30'h7fffee; l = 5'd23; end
      8'd183: begin c = 30'h7fffef; l = 5'd23; end
      8'd184: begin c = 30'hfffea; l = 5'd20; end
      8'd185: begin c = 30'h3fffe2; l = 5'd22; end
      8'd186: begin c = 30'h3fffe3; l = 5'd22; end
      8'd187: begin c = 30'h3fffe4; l = 5'd22; end
      8'd188: begin c = 30'h7ffff0; l = 5'd23; end
      8'd189: begin c = 30'h3fffe5; l = 5'd22; end
      8'd190: begin c = 30'h3fffe6; l = 5'd22; end
      8'd191: begin c = 30'h7ffff1; l = 5'd23; end
      8'd192: begin c = 30'h3ffffe0; l = 5'd26; end
      8'd193: begin c = 30'h3ffffe1; l = 5'd26; end
      8'd194: begin c = 30'hfffeb; l = 5'd20; end
      8'd195: begin c = 30'h7fff1; l = 5'd19; end
      8'd196: begin c = 30'h3fffe7; l = 5'd22; end
      8'd197: begin c = 30'h7ffff2; l = 5'd23; end
      8'd198: begin c = 30'h3fffe8; l = 5'd22; end
      8'd199: begin c = 30'h1ffffec; l = 5'd25; end
      8'd200: begin c = 30'h3ffffe2; l = 5'd26; end
      8'd201: begin c = 30'h3ffffe3; l = 5'd26; end
      8'd202: begin c = 30'h3ffffe4; l = 5'd26; end
      8'd203: begin c = 30'h7ffffde; l = 5'd27; end
      8'd204: begin c = 30'h7ffffdf; l = 5'd27; end
      8'd205: begin c = 30'h3ffffe5; l = 5'd26; end
      8'd206: begin c = 30'hfffff1; l = 5'd24; end
      8'd207: begin c = 30'h1ffffed; l = 5'd25; end
      8'd208: begin c = 30'h7fff2; l = 5'd19; end
      8'd209: begin c = 30'h1fffe3; l = 5'd21; end
      8'd210: begin c = 30'h3ffffe6; l = 5'd26; end
      8'd211: begin c = 30'h7ffffe0; l = 5'd27; end
      8'd212: begin c = 30'h7ffffe1; l = 5'd27; end
      8'd213: begin c = 30'h3ffffe7; l = 5'd26; end
      8'd214: begin c = 30'h7ffffe2; l = 5'd27; end
      8'd215: begin c = 30'hfffff2; l = 5'd24; end
      8'd216: begin c = 30'h1fffe4; l = 5'd21; end
      8'd217: begin c = 30'h1fffe5; l = 5'd21; end
      8'd218: begin c = 30'h3ffffe8; l = 5'd26; end
      8'd219: begin c = 30'h3ffffe9; l = 5'd26; end
      8'd220: begin c = 30'hffffffd; l = 5'd28; end
      8'd221: begin c = 30'h7ffffe3; l = 5'd27; end
      8'd222: begin c = 30'h7ffffe4; l = 5'd27; end
      8'd223: begin c = 30'h7ffffe5; l = 5'd27; end
      8'd224: begin c = 30'hfffec; l = 5'd20; end
      8'd225: begin c = 30'hfffff3; l = 5'd24; end
      8'd226: begin c = 30'hfffed; l = 5'd20; end
      8'd227: begin c = 30'h1fffe6; l = 5'd21; end
      8'd228: begin c = 30'h3fffe9; l = 5'd22; end
      8'd229: begin c = 30'h1fffe7; l = 5'd21; end
      8'd230: begin c = 30'h1fffe8; l = 5'd21; end
      8'd231: begin c = 30'h7ffff3; l = 5'd23; end
      8'd232: begin c = 30'h3fffea; l = 5'd22; end
      8'd233: begin c = 30'h3fffeb; l = 5'd22; end
      8'd234: begin c = 30'h1ffffee; l = 5'd25; end
      8'd235: begin c = 30'h1ffffef; l = 5'd25; end
      8'd236: begin c = 30'hfffff4; l = 5'd24; end
      8'd237: begin c = 30'hfffff5; l = 5'd24; end
      8'd238: begin c = 30'h3ffffea; l = 5'd26; end
      8'd239: begin c = 30'h7ffff4; l = 5'd23; end
      8'd240: begin c = 30'h3ffffeb; l = 5'd26; end
      8'd241: begin c = 30'h7ffffe6; l = 5'd27; end
      8'd242: begin c = 30'h3ffffec; l = 5'd26; end
      8'd243: begin c = 30'h3ffffed; l = 5'd26; end
      8'd244: begin c = 30'h7ffffe7; l = 5'd27; end
      8'd245: begin c = 30'h7ffffe8; l = 5'd27; end
      8'd246: begin c = 30'h7ffffe9; l = 5'd27; end
      8'd247: begin c = 30'h7ffffea; l = 5'd27; end
      8'd248: begin c = 30'h7ffffeb; l = 5'd27; end
      8'd249: begin c = 30'hffffffe; l = 5'd28; end
      8'd250: begin c = 30'h7ffffec; l = 5'd27; end
      8'd251: begin c = 30'h7ffffed; l = 5'd27; end
      8'd252: begin c = 30'h7ffffee; l = 5'd27; end
      8'd253: begin c = 30'h7ffffef; l = 5'd27; end
      8'd254: begin c = 30'h7fffff0; l = 5'd27; end
      default: begin c = 30'h3ffffee; l = 5'd26; end
    endcase
    return {l, c};
  endfunction

endpackage
`default_nettype wire

// File: hdl/hpe_ram.sv
`default_nettype none
module hpe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: hdl/hpe_code_rom.sv
`default_nettype none
module hpe_code_rom (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic [7:0]               symbol,
  output logic      [hpe_pkg::CODE_W-1:0] code,
  output logic      [hpe_pkg::LEN_W-1:0]  len
);

  // Registered lookup, like the context memory.
  always_ff @(posedge clk) begin
    if (en) begin
      {len, code} <= hpe_pkg::code_entry(symbol);
    end
  end

endmodule
`default_nettype wire

// File: hdl/hpack_huffman_encoder.sv
`default_nettype none
// Static Huffman encoder: one input byte per transfer, up to four code bytes plus pad/overflow.
// Stages per input: context read and ROM lookup, merge, emit loop into the output register.
// A new input is accepted only in idle, once the emit loop is done with the previous one;
// output backpressure stalls the emit loop. Context (bit queue and flags) lives in entry 0
// of a two-entry synchronous RAM, read and written back once per item.
// Synchronous active-low reset clears the control state and counters.
module hpack_huffman_encoder #(
  parameter int COUNT_WIDTH = hpe_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // symbol[7:0], capacity[23:8]
  input  wire logic        in_tlast,   // last
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // out_byte[7:0], produced[23:8], consumed[39:24]
  output logic             out_tlast,  // end_of_string
  output logic             out_tuser   // overflow
);

  localparam int QW = hpe_pkg::QUEUE_W;
  localparam int BW = hpe_pkg::BITS_W;
  localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

  hpe_pkg::state_t state_r, state_nxt;

  logic [7:0]  sym_r;
  logic        last_r;
  logic [15:0] cap_r;
  logic [15:0] room_r, room_nxt;
  logic [COUNT_WIDTH-1:0] bout_r, bout_nxt, bin_r, bin_nxt;
  logic [QW-1:0] q_r, q_nxt;
  logic [BW-1:0] cnt_r, cnt_nxt;

  hpe_pkg::ctx_t ctx_rd, ctx_wr;
  logic ctx_we, valid_r;
  logic [hpe_pkg::CODE_W-1:0] code;
  logic [hpe_pkg::LEN_W-1:0]  len;

  logic        obuf_v_r, obuf_v_nxt;
  logic [7:0]  obyte_r, obyte_nxt;
  logic        oeos_r, oeos_nxt, oovf_r, oovf_nxt;
  logic [15:0] oprod_r, oprod_nxt, ocons_r, ocons_nxt;

  hpe_ram #(.WIDTH(hpe_pkg::CTX_W), .DEPTH(2)) u_ctx (
    .clk  (clk),
    .we   (ctx_we),
    .waddr(1'b0),
    .wdata(ctx_wr),
    .raddr(1'b0),
    .rdata(ctx_rd)
  );

  hpe_code_rom u_rom (
    .clk   (clk),
    .en    (state_r == hpe_pkg::ST_READ),
    .symbol(sym_r),
    .code  (code),
    .len   (len)
  );

  logic accept;
  assign in_tready = (state_r == hpe_pkg::ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  wire   slot_free = !obuf_v_r || out_tready;

  // Effective context: memory content gated by its valid-after-reset bit.
  hpe_pkg::ctx_t ctx_eff;
  always_comb begin
    ctx_eff = ctx_rd;
    if (!valid_r) begin
      ctx_eff = '0;
    end
  end

  logic [BW-1:0] sh;
  logic [3:0]    fill;
  logic [7:0]    pad_byte;
  always_comb begin
    sh       = cnt_r - BW'(8);
    fill     = 4'd8 - 4'(cnt_r);
    pad_byte = 8'((q_r << fill) | ~(hpe_pkg::BYTE_ONES << fill));
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hpe_pkg::ST_IDLE: if (accept) state_nxt = hpe_pkg::ST_READ;
      hpe_pkg::ST_READ: state_nxt = hpe_pkg::ST_LOAD;
      hpe_pkg::ST_LOAD: begin
        if (ctx_eff.in_string && ctx_eff.discarding) state_nxt = hpe_pkg::ST_IDLE;
        else if (((ctx_eff.in_string) ? room_r : cap_r) == 16'd0)
          state_nxt = hpe_pkg::ST_ABORT;
        else state_nxt = hpe_pkg::ST_EMIT;
      end
      hpe_pkg::ST_EMIT: begin
        if (slot_free) begin
          if (cnt_r >= BW'(8)) begin
            if (room_r == 16'd0) state_nxt = hpe_pkg::ST_ABORT;
          end else if (last_r && cnt_r != '0) state_nxt = hpe_pkg::ST_PAD;
          else state_nxt = hpe_pkg::ST_IDLE;
        end
      end
      hpe_pkg::ST_PAD: begin
        if (slot_free) begin
          if (room_r == 16'd0) state_nxt = hpe_pkg::ST_ABORT;
          else state_nxt = hpe_pkg::ST_IDLE;
        end
      end
      hpe_pkg::ST_ABORT: if (slot_free) state_nxt = hpe_pkg::ST_IDLE;
      default: state_nxt = hpe_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    room_nxt   = room_r;
    bout_nxt   = bout_r;
    bin_nxt    = bin_r;
    q_nxt      = q_r;
    cnt_nxt    = cnt_r;
    ctx_we     = 1'b0;
    ctx_wr     = '0;
    obuf_v_nxt = obuf_v_r && !out_tready;
    obyte_nxt  = obyte_r;
    oeos_nxt   = oeos_r;
    oovf_nxt   = oovf_r;
    oprod_nxt  = oprod_r;
    ocons_nxt  = ocons_r;
    unique case (state_r)
      hpe_pkg::ST_LOAD: begin
        if (!ctx_eff.in_string) begin
          room_nxt = cap_r;
          bout_nxt = '0;
          bin_nxt  = '0;
          q_nxt    = '0;
          cnt_nxt  = '0;
        end else begin
          q_nxt   = ctx_eff.queue;
          cnt_nxt = ctx_eff.count;
        end
        if (ctx_eff.in_string && ctx_eff.discarding) begin
          ctx_we = 1'b1;
          ctx_wr = '{queue: '0, count: '0, in_string: !last_r, discarding: !last_r};
        end else if (((ctx_eff.in_string) ? room_r : cap_r) != 16'd0) begin
          bin_nxt = (ctx_eff.in_string && bin_r == CMAX) ? bin_r
                  : ((ctx_eff.in_string ? bin_r : '0) + 1'b1);
          q_nxt   = QW'(({(ctx_eff.in_string ? ctx_eff.queue : QW'(0))} << len)
                  | QW'(code));
          cnt_nxt = (ctx_eff.in_string ? ctx_eff.count : BW'(0)) + BW'(len);
        end
      end
      hpe_pkg::ST_EMIT: begin
        if (slot_free && cnt_r >= BW'(8) && room_r != 16'd0) begin
          obuf_v_nxt = 1'b1;
          obyte_nxt  = 8'(q_r >> sh);
          room_nxt   = room_r - 16'd1;
          bout_nxt   = (bout_r == CMAX) ? bout_r : bout_r + 1'b1;
          cnt_nxt    = sh;
          q_nxt      = q_r & ~({QW{1'b1}} << sh);
          oeos_nxt   = last_r && sh == '0;
          oovf_nxt   = 1'b0;
          oprod_nxt  = 16'(bout_nxt);
          ocons_nxt  = 16'(bin_r);
        end
        if (slot_free && cnt_r < BW'(8) && !(last_r && cnt_r != '0)) begin
          ctx_we = 1'b1;
          if (last_r) begin
            ctx_wr = '0;
          end else begin
            ctx_wr = '{queue: q_r, count: cnt_r, in_string: 1'b1, discarding: 1'b0};
          end
        end
      end
      hpe_pkg::ST_PAD: begin
        if (slot_free && room_r != 16'd0) begin
          obuf_v_nxt = 1'b1;
          obyte_nxt  = pad_byte;
          room_nxt   = room_r - 16'd1;
          bout_nxt   = (bout_r == CMAX) ? bout_r : bout_r + 1'b1;
          oeos_nxt   = 1'b1;
          oovf_nxt   = 1'b0;
          oprod_nxt  = 16'(bout_nxt);
          ocons_nxt  = 16'(bin_r);
          ctx_we     = 1'b1;
          ctx_wr     = '0;
        end
      end
      hpe_pkg::ST_ABORT: begin
        if (slot_free) begin
          obuf_v_nxt = 1'b1;
          obyte_nxt  = '0;
          oeos_nxt   = 1'b1;
          oovf_nxt   = 1'b1;
          oprod_nxt  = 16'(bout_r);
          ocons_nxt  = 16'(bin_r);
          ctx_we     = 1'b1;
          ctx_wr     = '{queue: '0, count: '0, in_string: !last_r, discarding: !last_r};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= hpe_pkg::ST_IDLE;
      valid_r  <= 1'b0;
      obuf_v_r <= 1'b0;
      room_r   <= '0;
      bout_r   <= '0;
      bin_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      obuf_v_r <= obuf_v_nxt;
      room_r   <= room_nxt;
      bout_r   <= bout_nxt;
      bin_r    <= bin_nxt;
      if (ctx_we) valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sym_r  <= in_tdata[7:0];
      cap_r  <= in_tdata[23:8];
      last_r <= in_tlast;
    end
    q_r     <= q_nxt;
    cnt_r   <= cnt_nxt;
    obyte_r <= obyte_nxt;
    oeos_r  <= oeos_nxt;
    oovf_r  <= oovf_nxt;
    oprod_r <= oprod_nxt;
    ocons_r <= ocons_nxt;
  end

  assign out_tvalid = obuf_v_r;
  assign out_tdata  = {ocons_r, oprod_r, obyte_r};
  assign out_tlast  = oeos_r;
  assign out_tuser  = oovf_r;

endmodule
`default_nettype wire

// File: bench/hpack_huffman_encoder_tb.sv
`default_nettype none
module hpack_huffman_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        eos;
    logic        ovf;
    logic [15:0] produced;
    logic [15:0] consumed;
  } enc_result_t;

  // Static Huffman table, split out of the package entry by field position only.
  function automatic logic [29:0] huff_code(logic [7:0] s);
    logic [34:0] e;
    e = hpe_pkg::code_entry(s);
    return e[29:0];
  endfunction

  function automatic logic [4:0] huff_len(logic [7:0] s);
    logic [34:0] e;
    e = hpe_pkg::code_entry(s);
    return e[34:30];
  endfunction

  // Tracks expected encoder output and compares it against what the block sends.
  class huff_scoreboard;
    logic [36:0] bitq;
    int unsigned nbits;
    int unsigned room;
    int unsigned n_out;
    int unsigned n_in;
    bit active;
    bit dropping;
    enc_result_t pending[$];
    int errors;

    function void clear();
      bitq = '0; nbits = 0; room = 0; n_out = 0; n_in = 0;
      active = 0; dropping = 0; pending.delete(); errors = 0;
    endfunction

    function void push(logic [7:0] b, bit eos, bit ovf);
      enc_result_t r;
      r.out_byte = b; r.eos = eos; r.ovf = ovf;
      r.produced = n_out[15:0]; r.consumed = n_in[15:0];
      pending.push_back(r);
    endfunction

    function void abort_run(bit last);
      push(8'h00, 1, 1);
      bitq = '0; nbits = 0;
      if (last) begin
        active = 0; dropping = 0;
      end else begin
        dropping = 1;
      end
    endfunction

    function void note_symbol(logic [7:0] sym, bit last, logic [15:0] cap);
      logic [29:0] code;
      int unsigned len, fill, added;
      logic [7:0] b;
      logic [63:0] wide;
      if (!active) begin
        active = 1; dropping = 0; bitq = '0; nbits = 0;
        room = {16'd0, cap}; n_out = 0; n_in = 0;
      end
      if (dropping) begin
        if (last) begin
          active = 0; dropping = 0;
        end
        return;
      end
      if (room == 0) begin
        abort_run(last);
        return;
      end
      if (n_in < 16'hFFFF) n_in++;
      {len, code} = {27'd0, huff_len(sym), huff_code(sym)};
      wide = ({27'd0, bitq} << len) | {34'd0, code};
      bitq = wide[36:0];
      nbits += len;
      added = 0;
      while (nbits >= 8) begin
        if (room == 0) begin
          abort_run(last);
          return;
        end
        b = 8'(bitq >> (nbits - 8));
        room--;
        if (n_out < 16'hFFFF) n_out++;
        nbits -= 8;
        bitq &= (37'd1 << nbits) - 37'd1;
        push(b, 0, 0);
        added++;
      end
      if (last) begin
        if (nbits > 0) begin
          if (room == 0) begin
            abort_run(1);
            return;
          end
          fill = 8 - nbits;
          wide = ({27'd0, bitq} << fill) | ((64'd1 << fill) - 64'd1);
          room--;
          if (n_out < 16'hFFFF) n_out++;
          push(wide[7:0], 1, 0);
        end else if (added > 0) begin
          pending[pending.size()-1].eos = 1;
        end
        bitq = '0; nbits = 0; active = 0;
      end
    endfunction

    function void check(enc_result_t got);
      enc_result_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display({"result mismatch: expected byte %h eos %b ovf %b prod %0d cons %0d,",
                    " got byte %h eos %b ovf %b prod %0d cons %0d"},
                   want.out_byte, want.eos, want.ovf, want.produced, want.consumed,
                   got.out_byte, got.eos, got.ovf, got.produced, got.consumed);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [23:0] in_tdata = '0;
  logic in_tlast = 0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [39:0] out_tdata;
  logic out_tlast;
  logic out_tuser;

  int send_idle_pct = 33;
  int recv_idle_pct = 50;
  int stall_cycles = 0;
  huff_scoreboard board;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  hpack_huffman_encoder dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast, .out_tuser
  );

  always @(posedge clk) begin
    enc_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.out_byte = out_tdata[7:0];
      got.produced = out_tdata[23:8];
      got.consumed = out_tdata[39:24];
      got.eos = out_tlast;
      got.ovf = out_tuser;
      board.check(got);
    end
    if (rst_n && !((in_tvalid && in_tready) || (out_tvalid && out_tready)))
      stall_cycles++;
    else
      stall_cycles = 0;
    if (stall_cycles >= 20000) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(negedge clk)
    out_tready <= ($urandom_range(99) >= recv_idle_pct);

  // Leave tvalid high after the transfer; the next call drops it or presents a new symbol, drain() drops it.
  task automatic send_symbol(logic [7:0] sym, bit last, logic [15:0] cap);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(negedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {cap, sym};
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    board.note_symbol(sym, last, cap);
    @(negedge clk);
  endtask

  task automatic send_string(int len, logic [15:0] cap, int sym_kind);
    logic [7:0] s;
    for (int i = 0; i < len; i++) begin
      case (sym_kind)
        0: s = 8'($urandom_range(255));
        1: s = 8'(8'd48 + $urandom_range(74));
        default: s = $urandom_range(1) ? 8'd10 : 8'd255;
      endcase
      send_symbol(s, i == len - 1, (i == 0) ? cap : 16'($urandom_range(65535)));
    end
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (board.pending.size() != 0) @(negedge clk);
  endtask

  task automatic random_phase(int count);
    int len;
    int cap;
    while (count > 0) begin
      len = $urandom_range(1, 8);
      case ($urandom_range(9))
        0: cap = 0;
        1, 2: cap = $urandom_range(1, 3);
        3: cap = 16'hFFFF;
        4: cap = $urandom_range(65535);
        default: cap = $urandom_range(4, 40);
      endcase
      if (cap == 16'hFFFF || cap == 0 || cap > 40)
        send_string(len, 16'(cap), 3 * (cap == 0));
      else
        send_string(len, 16'(cap), int'($urandom_range(1)));
      count -= len;
    end
  endtask

  initial begin
    board = new();
    board.clear();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // Directed: single bytes at the extremes, exact boundary, tight capacity,
    // zero capacity, overflow mid-string, drop until last.
    send_symbol(8'd48, 1, 16'd1);
    send_symbol(8'd38, 1, 16'd1);
    send_symbol(8'd255, 1, 16'hFFFF);
    send_symbol(8'd10, 0, 16'd2);
    send_symbol(8'd13, 1, 16'd0);
    send_symbol(8'd0, 1, 16'd0);
    send_symbol(8'd22, 0, 16'd3);
    send_symbol(8'd97, 0, 16'd3);
    send_symbol(8'd98, 1, 16'd3);
    send_symbol(8'd38, 0, 16'd1);
    send_symbol(8'd38, 1, 16'd5);
    send_symbol(8'd200, 0, 16'd1);
    send_symbol(8'd1, 0, 16'd9);
    send_symbol(8'd128, 1, 16'd9);
    send_symbol(8'd0, 1, 16'd1);
    send_symbol(8'd255, 1, 16'h8000);
    send_symbol(8'd127, 1, 16'h7FFF);
    drain();

    random_phase(170);
    drain();
    send_idle_pct = 50;
    recv_idle_pct = 33;
    random_phase(170);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(170);
    drain();
    repeat (20) @(negedge clk);

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
`default_nettype wire
